### rtl/c_subset_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef C_SUBSET_TOKENIZER_DEFINES_SVH
`define C_SUBSET_TOKENIZER_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked property, switched off while reset is high.
`define CTOK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tokenizer assertion failed");

// Clocked property that also holds during reset.
`define CTOK_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("tokenizer assertion failed");

`else

`define CTOK_ASSERT(lbl, clk, rst, prop)
`define CTOK_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### rtl/ctok_pkg.sv
// Shared types, token codes and keyword table of the tokenizer.
`timescale 1ns / 1ps

package ctok_pkg;

   localparam int MAX_TOKEN_CHARS_DEF = 255;
   localparam int PREFIX_LEN          = 6;
   localparam int KW_COUNT            = 7;
   // result queue; must be a power of two and at least two
   localparam int RSP_DEPTH           = 4;

   // token kinds
   localparam logic [4:0] K_END     = 5'd0;
   localparam logic [4:0] K_INT     = 5'd1;
   localparam logic [4:0] K_LBRACE  = 5'd8;
   localparam logic [4:0] K_RBRACE  = 5'd9;
   localparam logic [4:0] K_LPAREN  = 5'd10;
   localparam logic [4:0] K_RPAREN  = 5'd11;
   localparam logic [4:0] K_SEMI    = 5'd12;
   localparam logic [4:0] K_COMMA   = 5'd13;
   localparam logic [4:0] K_IDENT   = 5'd14;
   localparam logic [4:0] K_NUMBER  = 5'd15;
   localparam logic [4:0] K_PLUS    = 5'd16;
   localparam logic [4:0] K_MINUS   = 5'd17;
   localparam logic [4:0] K_STAR    = 5'd18;
   localparam logic [4:0] K_SLASH   = 5'd19;
   localparam logic [4:0] K_LESS    = 5'd20;
   localparam logic [4:0] K_GREATER = 5'd21;
   localparam logic [4:0] K_EQ      = 5'd22;
   localparam logic [4:0] K_NE      = 5'd23;
   localparam logic [4:0] K_LE      = 5'd24;
   localparam logic [4:0] K_GE      = 5'd25;
   localparam logic [4:0] K_INVALID = 5'd26;

   typedef logic [PREFIX_LEN-1:0][7:0] prefix_type;

   // keyword spellings, first character in element 0, zero padded
   localparam prefix_type KW_TEXT [KW_COUNT] = '{
      {8'h00, 8'h00, 8'h00, "t", "n", "i"},
      {8'h00, 8'h00, "d", "i", "o", "v"},
      {8'h00, 8'h00, 8'h00, 8'h00, "f", "i"},
      {8'h00, 8'h00, "e", "s", "l", "e"},
      {8'h00, "e", "l", "i", "h", "w"},
      {8'h00, 8'h00, 8'h00, "r", "o", "f"},
      {"n", "r", "u", "t", "e", "r"}
   };
   localparam logic [7:0] KW_LEN [KW_COUNT] = '{
      8'd3, 8'd4, 8'd2, 8'd4, 8'd5, 8'd3, 8'd6
   };

   typedef struct packed {
      logic [4:0]  kind;
      logic [7:0]  len;
      logic [31:0] value;
      logic [15:0] line;
      logic        last;
   } result_type;

   // results of one request: up to two, r0 first
   typedef struct packed {
      logic [1:0] cnt;
      result_type r0;
      result_type r1;
   } step_type;

   // keyword or identifier for a finished word
   function automatic logic [4:0] word_kind(input prefix_type prefix,
                                            input logic [7:0] chars,
                                            input logic       mism);
      logic [4:0] kind;
      kind = K_IDENT;
      if (!mism) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            if (chars == KW_LEN[k] && prefix == KW_TEXT[k]) begin
               kind = K_INT + 5'(k);
            end
         end
      end
      return kind;
   endfunction

endpackage

### rtl/ctok_lexer.sv
// Scanner state and per-character token decisions.
`timescale 1ns / 1ps
`include "c_subset_tokenizer_defines.svh"

module ctok_lexer #(
   parameter int MAX_TOKEN_CHARS = ctok_pkg::MAX_TOKEN_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        char_code,
   input  logic              end_of_input,
   output ctok_pkg::step_type step
);
   import ctok_pkg::*;

   typedef enum logic [3:0] {
      M_IDLE, M_WORD, M_DIGITS, M_SLASH, M_LINECOM, M_BLOCKCOM,
      M_BLOCKSTAR, M_LESS, M_GREATER, M_BANG, M_EQS
   } mode_type;

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_BANG = "!";
   localparam logic [7:0] CH_LPAR = "(";
   localparam logic [7:0] CH_RPAR = ")";
   localparam logic [7:0] CH_STAR = "*";
   localparam logic [7:0] CH_PLUS = "+";
   localparam logic [7:0] CH_COMMA = ",";
   localparam logic [7:0] CH_MINUS = "-";
   localparam logic [7:0] CH_SLASH = "/";
   localparam logic [7:0] CH_0 = "0";
   localparam logic [7:0] CH_9 = "9";
   localparam logic [7:0] CH_SEMI = ";";
   localparam logic [7:0] CH_LT = "<";
   localparam logic [7:0] CH_EQ = "=";
   localparam logic [7:0] CH_GT = ">";
   localparam logic [7:0] CH_UA = "A";
   localparam logic [7:0] CH_UZ = "Z";
   localparam logic [7:0] CH_US = "_";
   localparam logic [7:0] CH_LA = "a";
   localparam logic [7:0] CH_LZ = "z";
   localparam logic [7:0] CH_LBRACE = "{";
   localparam logic [7:0] CH_RBRACE = "}";

   mode_type   mode_ff, mode_in;
   logic [7:0] chars_ff, chars_in;
   prefix_type prefix_ff, prefix_in;
   logic       mism_ff, mism_in;
   logic [31:0] value_ff, value_in;
   logic [15:0] line_ff, line_in;
   logic       fin_ff, fin_in;

   logic       is_digit, is_alnum;
   logic [15:0] line_next;
   logic       pend_ok;
   result_type pend_res;
   mode_type   byte_mode;
   logic       byte_ok;
   logic [4:0] byte_kind;
   logic       fall;
   logic [4:0] last_kind;

   function automatic result_type mk(input logic [4:0] kind, input logic [7:0] len,
                                     input logic [31:0] value, input logic [15:0] line,
                                     input logic last);
      result_type r;
      r.kind  = kind;
      r.len   = len;
      r.value = value;
      r.line  = line;
      r.last  = last;
      return r;
   endfunction

   assign is_digit  = (char_code >= CH_0) && (char_code <= CH_9);
   assign is_alnum  = is_digit || char_code == CH_US ||
                      (char_code >= CH_LA && char_code <= CH_LZ) ||
                      (char_code >= CH_UA && char_code <= CH_UZ);
   assign line_next = (char_code == CH_LF && line_ff != 16'hFFFF) ? line_ff + 16'd1 : line_ff;

   // token held over from earlier characters
   always_comb begin
      pend_ok  = 1'b1;
      pend_res = mk(K_INVALID, 8'd0, 32'd0, line_next, 1'b0);
      unique case (mode_ff)
         M_WORD:    pend_res.kind = word_kind(prefix_ff, chars_ff, mism_ff);
         M_DIGITS:  pend_res.kind = K_NUMBER;
         M_SLASH:   pend_res.kind = K_SLASH;
         M_LESS:    pend_res.kind = K_LESS;
         M_GREATER: pend_res.kind = K_GREATER;
         M_BANG, M_EQS: pend_res.kind = K_INVALID;
         default:   pend_ok = 1'b0;
      endcase
      if (mode_ff == M_WORD || mode_ff == M_DIGITS) begin
         pend_res.len = chars_ff;
      end
      if (mode_ff == M_DIGITS) begin
         pend_res.value = value_ff;
      end
   end

   // what a character does when seen from idle
   always_comb begin
      byte_mode = M_IDLE;
      byte_ok   = 1'b0;
      byte_kind = K_INVALID;
      case (char_code) inside
         CH_SP, CH_TAB, CH_LF, CH_CR: begin
         end
         [CH_LA:CH_LZ], [CH_UA:CH_UZ], CH_US: byte_mode = M_WORD;
         [CH_0:CH_9]: byte_mode = M_DIGITS;
         CH_SLASH:  byte_mode = M_SLASH;
         CH_LT:     byte_mode = M_LESS;
         CH_GT:     byte_mode = M_GREATER;
         CH_BANG:   byte_mode = M_BANG;
         CH_EQ:     byte_mode = M_EQS;
         CH_LBRACE: begin byte_ok = 1'b1; byte_kind = K_LBRACE; end
         CH_RBRACE: begin byte_ok = 1'b1; byte_kind = K_RBRACE; end
         CH_LPAR:   begin byte_ok = 1'b1; byte_kind = K_LPAREN; end
         CH_RPAR:   begin byte_ok = 1'b1; byte_kind = K_RPAREN; end
         CH_SEMI:   begin byte_ok = 1'b1; byte_kind = K_SEMI; end
         CH_COMMA:  begin byte_ok = 1'b1; byte_kind = K_COMMA; end
         CH_PLUS:   begin byte_ok = 1'b1; byte_kind = K_PLUS; end
         CH_MINUS:  begin byte_ok = 1'b1; byte_kind = K_MINUS; end
         CH_STAR:   begin byte_ok = 1'b1; byte_kind = K_STAR; end
         default:   byte_ok = 1'b1;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      chars_in  = chars_ff;
      prefix_in = prefix_ff;
      mism_in   = mism_ff;
      value_in  = value_ff;
      line_in   = line_ff;
      fin_in    = fin_ff;
      fall      = 1'b0;
      step      = '0;

      if (take) begin
         if (fin_ff) begin
            step.cnt = 2'd1;
            step.r0  = mk(K_END, 8'd0, 32'd0, line_ff, 1'b1);
         end else if (end_of_input) begin
            mode_in = M_IDLE;
            fin_in  = 1'b1;
            if (pend_ok) begin
               step.cnt     = 2'd2;
               step.r0      = pend_res;
               step.r0.line = line_ff;
               step.r1      = mk(K_END, 8'd0, 32'd0, line_ff, 1'b1);
            end else begin
               step.cnt = 2'd1;
               step.r0  = mk(K_END, 8'd0, 32'd0, line_ff, 1'b1);
            end
         end else begin
            line_in = line_next;
            unique case (mode_ff)
               M_WORD: begin
                  if (is_alnum) begin
                     if (chars_ff < 8'(MAX_TOKEN_CHARS)) begin
                        if (chars_ff < 8'(PREFIX_LEN)) begin
                           prefix_in[chars_ff[2:0]] = char_code;
                        end else begin
                           mism_in = 1'b1;
                        end
                        chars_in = chars_ff + 8'd1;
                     end
                  end else begin
                     fall = 1'b1;
                  end
               end
               M_DIGITS: begin
                  if (is_digit) begin
                     if (chars_ff < 8'(MAX_TOKEN_CHARS)) begin
                        // x*10 + d as two shifts and adds
                        value_in = (value_ff << 3) + (value_ff << 1) + {28'd0, char_code[3:0]};
                        chars_in = chars_ff + 8'd1;
                     end
                  end else begin
                     fall = 1'b1;
                  end
               end
               M_SLASH: begin
                  if (char_code == CH_SLASH) begin
                     mode_in = M_LINECOM;
                  end else if (char_code == CH_STAR) begin
                     mode_in = M_BLOCKCOM;
                  end else begin
                     fall = 1'b1;
                  end
               end
               M_LINECOM: begin
                  if (char_code == CH_LF) begin
                     mode_in = M_IDLE;
                  end
               end
               M_BLOCKCOM: begin
                  if (char_code == CH_STAR) begin
                     mode_in = M_BLOCKSTAR;
                  end
               end
               M_BLOCKSTAR: begin
                  if (char_code == CH_SLASH) begin
                     mode_in = M_IDLE;
                  end else if (char_code != CH_STAR) begin
                     mode_in = M_BLOCKCOM;
                  end
               end
               M_LESS, M_GREATER, M_BANG, M_EQS: begin
                  if (char_code == CH_EQ) begin
                     mode_in  = M_IDLE;
                     step.cnt = 2'd1;
                     step.r0  = mk(K_EQ, 8'd0, 32'd0, line_next, 1'b1);
                     if (mode_ff == M_LESS) begin
                        step.r0.kind = K_LE;
                     end else if (mode_ff == M_GREATER) begin
                        step.r0.kind = K_GE;
                     end else if (mode_ff == M_BANG) begin
                        step.r0.kind = K_NE;
                     end
                  end else begin
                     fall = 1'b1;
                  end
               end
               default: fall = 1'b1;
            endcase

            // finish any held token, then treat the character as fresh
            if (fall) begin
               mode_in = byte_mode;
               if (byte_mode == M_WORD) begin
                  prefix_in    = '0;
                  prefix_in[0] = char_code;
                  mism_in      = 1'b0;
                  chars_in     = 8'd1;
               end
               if (byte_mode == M_DIGITS) begin
                  value_in = {28'd0, char_code[3:0]};
                  chars_in = 8'd1;
               end
               if (pend_ok && byte_ok) begin
                  step.cnt = 2'd2;
                  step.r0  = pend_res;
                  step.r1  = mk(byte_kind, 8'd0, 32'd0, line_next, 1'b1);
               end else if (pend_ok) begin
                  step.cnt     = 2'd1;
                  step.r0      = pend_res;
                  step.r0.last = 1'b1;
               end else if (byte_ok) begin
                  step.cnt = 2'd1;
                  step.r0  = mk(byte_kind, 8'd0, 32'd0, line_next, 1'b1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         chars_ff  <= 8'd0;
         prefix_ff <= '0;
         mism_ff   <= 1'b0;
         value_ff  <= 32'd0;
         line_ff   <= 16'd1;
         fin_ff    <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         chars_ff  <= chars_in;
         prefix_ff <= prefix_in;
         mism_ff   <= mism_in;
         value_ff  <= value_in;
         line_ff   <= line_in;
         fin_ff    <= fin_in;
      end
   end

   // kind of the last token of this request
   assign last_kind = (step.cnt == 2'd2) ? step.r1.kind : step.r0.kind;

   `CTOK_ASSERT(a_fin_sticky, clock, reset, fin_ff |=> fin_ff)
   `CTOK_ASSERT(a_line_nonzero, clock, reset, line_ff != 16'd0)
   `CTOK_ASSERT(a_chars_cap, clock, reset, chars_ff <= 8'(MAX_TOKEN_CHARS))
   `CTOK_ASSERT(a_eoi_end, clock, reset, (take && end_of_input) |-> (last_kind == K_END))

endmodule

### rtl/ctok_rsp_queue.sv
// Small result queue taking up to two results per cycle, giving one.
`timescale 1ns / 1ps
`include "c_subset_tokenizer_defines.svh"

module ctok_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  ctok_pkg::step_type   push,
   output logic                 push_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ctok_pkg::result_type rsp
);
   import ctok_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   result_type       entry_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign rsp_valid  = count_ff != '0;
   assign rsp        = entry_ff[rd_ff];
   assign pop        = rsp_valid && !rsp_stall;
   // room for the two results a request may bring
   assign push_stall = count_ff > CNT_W'(RSP_DEPTH - 2);

   assign wr_in    = wr_ff + PTR_W'(push.cnt);
   assign rd_in    = rd_ff + PTR_W'(pop);
   assign count_in = count_ff + CNT_W'(push.cnt) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         entry_ff[wr_ff] <= push.r0;
      end
      if (push.cnt == 2'd2) begin
         entry_ff[wr_ff + PTR_W'(1)] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   `CTOK_ASSERT(a_count_cap, clock, reset, count_ff <= CNT_W'(RSP_DEPTH))
   `CTOK_ASSERT(a_push_room, clock, reset, (push.cnt != 2'd0) |-> !push_stall)
   `CTOK_ASSERT(a_idle_hold, clock, reset, (push.cnt == 2'd0 && !pop) |=> $stable(count_ff))

endmodule

### rtl/c_subset_tokenizer.sv
// Top level of the streaming C-subset tokenizer.
`timescale 1ns / 1ps

// Streaming tokenizer for a small C subset. Each request carries one source
// byte, or an end-of-input mark; the scanner updates its state at the
// accepting edge and hands zero, one or two tokens to a four-entry result
// queue, which drives the rsp_ side one token a cycle while rsp_stall is
// low, from the next cycle on. A new request is taken every cycle while
// the queue has room for two tokens, so the byte rate is one per cycle and
// the token rate at most one per cycle; that output port is the only limit.
// Blanks and comments give no token; every LF counts a line (saturating at
// 65535) and each token carries the line count after its byte. A token is
// emitted when the byte that ends it arrives; a lone '!' or '=' or an
// unknown byte gives an invalid token. End of input flushes any pending
// token, then an end token; after that every request returns one end token
// until reset. Words and numbers keep at most MAX_TOKEN_CHARS characters;
// rsp_is_last marks the last token caused by a request. No clearing pass
// is needed after reset.
module c_subset_tokenizer #(
   parameter int MAX_TOKEN_CHARS = ctok_pkg::MAX_TOKEN_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_input,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [7:0]  rsp_token_length,
   output logic [31:0] rsp_number_value,
   output logic [15:0] rsp_line_number,
   output logic        rsp_is_last
);
   import ctok_pkg::*;

   logic       take;
   step_type   step;
   result_type head;
   logic       q_stall;

   // a request is taken only when both of its possible tokens fit
   assign req_stall = q_stall;
   assign take      = req_valid && !q_stall;

   ctok_lexer #(
      .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
   ) u_lexer (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .char_code   (req_char_code),
      .end_of_input(req_end_of_input),
      .step        (step)
   );

   // decouples the one-token-a-cycle output from bytes that make two
   ctok_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_stall(q_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_length = head.len;
   assign rsp_number_value = head.value;
   assign rsp_line_number  = head.line;
   assign rsp_is_last      = head.last;

endmodule

### verif/token_stream_checker.sv
// Watches both channels of the tokenizer, predicts each token and compares.
`timescale 1ns / 1ps

module token_stream_checker #(
   parameter int MAX_CHARS = ctok_pkg::MAX_TOKEN_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_input,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [4:0]  rsp_token_kind,
   input  logic [7:0]  rsp_token_length,
   input  logic [31:0] rsp_number_value,
   input  logic [15:0] rsp_line_number,
   input  logic        rsp_is_last,
   output int          error_count,
   output int          tokens_pending
);
   import ctok_pkg::*;

   localparam logic [4:0] K_VOID   = K_INT + 5'd1;
   localparam logic [4:0] K_IF     = K_INT + 5'd2;
   localparam logic [4:0] K_ELSE   = K_INT + 5'd3;
   localparam logic [4:0] K_WHILE  = K_INT + 5'd4;
   localparam logic [4:0] K_FOR    = K_INT + 5'd5;
   localparam logic [4:0] K_RETURN = K_INT + 5'd6;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam int         HEAD_LEN = 6;
   localparam int         PRINT_CAP = 100;

   typedef enum logic [3:0] {
      S_IDLE, S_WORD, S_DIGITS, S_SLASH, S_LINE_COMMENT, S_BLOCK_COMMENT,
      S_BLOCK_STAR, S_LESS, S_GREATER, S_BANG, S_EQUALS
   } scan_state_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [7:0]  len;
      logic [31:0] value;
      logic [15:0] line;
      logic        last;
   } token_type;

   token_type tokens_due [$];

   scan_state_type            scan_state;
   logic [7:0]                word_len;
   logic [0:HEAD_LEN-1][7:0]  word_head;
   logic                      word_overlong;
   logic [31:0]               digit_sum;
   logic [15:0]               line_no;
   logic                      stream_done;

   int fails = 0;
   int pending_now = 0;

   assign error_count    = fails;
   assign tokens_pending = pending_now;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void push_token(input logic [4:0] k, input logic [7:0] n,
                                      input logic [31:0] v);
      token_type t;
      t.kind  = k;
      t.len   = n;
      t.value = v;
      t.line  = line_no;
      t.last  = 1'b0;
      tokens_due.push_back(t);
   endfunction

   // keyword only if the whole word fits the head and spells one exactly
   function automatic logic [4:0] word_token_kind();
      logic [4:0] k;
      k = K_IDENT;
      if (!word_overlong) begin
         case (word_head)
            {"int", 24'h0}:    k = K_INT;
            {"void", 16'h0}:   k = K_VOID;
            {"if", 32'h0}:     k = K_IF;
            {"else", 16'h0}:   k = K_ELSE;
            {"while", 8'h0}:   k = K_WHILE;
            {"for", 24'h0}:    k = K_FOR;
            {"return"}:        k = K_RETURN;
            default:           k = K_IDENT;
         endcase
      end
      return k;
   endfunction

   function automatic void flush_pending();
      case (scan_state)
         S_WORD:            push_token(word_token_kind(), word_len, 32'd0);
         S_DIGITS:          push_token(K_NUMBER, word_len, digit_sum);
         S_SLASH:           push_token(K_SLASH, 8'd0, 32'd0);
         S_LESS:            push_token(K_LESS, 8'd0, 32'd0);
         S_GREATER:         push_token(K_GREATER, 8'd0, 32'd0);
         S_BANG, S_EQUALS:  push_token(K_INVALID, 8'd0, 32'd0);
         default: ;
      endcase
      scan_state = S_IDLE;
   endfunction

   // byte seen from idle: opens a token or emits a one-character one
   function automatic void start_token(input logic [7:0] c);
      if (c == " " || c == "\t" || c == CH_LF || c == "\r") begin
      end else if (is_alpha(c)) begin
         scan_state    = S_WORD;
         word_head     = '0;
         word_head[0]  = c;
         word_overlong = 1'b0;
         word_len      = 8'd1;
      end else if (is_digit(c)) begin
         scan_state = S_DIGITS;
         digit_sum  = {24'h0, c - 8'd48};
         word_len   = 8'd1;
      end else begin
         case (c)
            "/":     scan_state = S_SLASH;
            "<":     scan_state = S_LESS;
            ">":     scan_state = S_GREATER;
            "!":     scan_state = S_BANG;
            "=":     scan_state = S_EQUALS;
            "{":     push_token(K_LBRACE, 8'd0, 32'd0);
            "}":     push_token(K_RBRACE, 8'd0, 32'd0);
            "(":     push_token(K_LPAREN, 8'd0, 32'd0);
            ")":     push_token(K_RPAREN, 8'd0, 32'd0);
            ";":     push_token(K_SEMI, 8'd0, 32'd0);
            ",":     push_token(K_COMMA, 8'd0, 32'd0);
            "+":     push_token(K_PLUS, 8'd0, 32'd0);
            "-":     push_token(K_MINUS, 8'd0, 32'd0);
            "*":     push_token(K_STAR, 8'd0, 32'd0);
            default: push_token(K_INVALID, 8'd0, 32'd0);
         endcase
      end
   endfunction

   function automatic void lex_byte(input logic [7:0] c, input logic eoi);
      int   base;
      logic relex;
      base  = tokens_due.size();
      relex = 1'b0;
      if (stream_done) begin
         push_token(K_END, 8'd0, 32'd0);
      end else if (eoi) begin
         flush_pending();
         push_token(K_END, 8'd0, 32'd0);
         stream_done = 1'b1;
      end else begin
         if (c == CH_LF && line_no != 16'hFFFF) line_no++;
         case (scan_state)
            S_WORD: begin
               if (is_alpha(c) || is_digit(c)) begin
                  if (word_len < MAX_CHARS) begin
                     if (word_len < HEAD_LEN) word_head[word_len] = c;
                     else word_overlong = 1'b1;
                     word_len++;
                  end
               end else relex = 1'b1;
            end
            S_DIGITS: begin
               if (is_digit(c)) begin
                  if (word_len < MAX_CHARS) begin
                     digit_sum = digit_sum * 32'd10 + {24'h0, c - 8'd48};
                     word_len++;
                  end
               end else relex = 1'b1;
            end
            S_SLASH: begin
               if (c == "/") scan_state = S_LINE_COMMENT;
               else if (c == "*") scan_state = S_BLOCK_COMMENT;
               else relex = 1'b1;
            end
            S_LINE_COMMENT: if (c == CH_LF) scan_state = S_IDLE;
            S_BLOCK_COMMENT: if (c == "*") scan_state = S_BLOCK_STAR;
            S_BLOCK_STAR: begin
               if (c == "/") scan_state = S_IDLE;
               else if (c != "*") scan_state = S_BLOCK_COMMENT;
            end
            S_LESS, S_GREATER, S_BANG, S_EQUALS: begin
               if (c == "=") begin
                  case (scan_state)
                     S_LESS:    push_token(K_LE, 8'd0, 32'd0);
                     S_GREATER: push_token(K_GE, 8'd0, 32'd0);
                     S_BANG:    push_token(K_NE, 8'd0, 32'd0);
                     default:   push_token(K_EQ, 8'd0, 32'd0);
                  endcase
                  scan_state = S_IDLE;
               end else relex = 1'b1;
            end
            default: relex = 1'b1;
         endcase
         if (relex) begin
            flush_pending();
            start_token(c);
         end
      end
      if (tokens_due.size() > base) tokens_due[tokens_due.size()-1].last = 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      if (fails < PRINT_CAP) $display("ERROR at %0t: %s", $time, what);
      fails++;
   endtask

   task automatic check_token();
      token_type want;
      if (tokens_due.size() == 0) begin
         report_mismatch($sformatf("unexpected token kind %0d", rsp_token_kind));
      end else begin
         want = tokens_due.pop_front();
         if (rsp_token_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", rsp_token_kind, want.kind));
         if (rsp_token_length !== want.len)
            report_mismatch($sformatf("length %0d, want %0d (kind %0d)",
                                      rsp_token_length, want.len, want.kind));
         if (rsp_number_value !== want.value)
            report_mismatch($sformatf("value %0d, want %0d (kind %0d)",
                                      rsp_number_value, want.value, want.kind));
         if (rsp_line_number !== want.line)
            report_mismatch($sformatf("line %0d, want %0d (kind %0d)",
                                      rsp_line_number, want.line, want.kind));
         if (rsp_is_last !== want.last)
            report_mismatch($sformatf("last flag %b, want %b (kind %0d)",
                                      rsp_is_last, want.last, want.kind));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scan_state    = S_IDLE;
         word_len      = 8'd0;
         word_head     = '0;
         word_overlong = 1'b0;
         digit_sum     = 32'd0;
         line_no       = 16'd1;
         stream_done   = 1'b0;
         tokens_due.delete();
      end else begin
         if (req_valid && !req_stall) lex_byte(req_char_code, req_end_of_input);
         if (rsp_valid && !rsp_stall) check_token();
      end
      pending_now = tokens_due.size();
   end

endmodule

### verif/tb_c_subset_tokenizer.sv
// Top of the tokenizer testbench: source byte stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

// The block lexes one source byte per request. This top only builds source
// text and drives it in; token_stream_checker sits beside the block, works
// out the tokens each accepted request should give and compares them.
//
// Flow of the run:
//   - reset once, at the start
//   - a short directed text: a keyword, a number ended by punctuation, a
//     lone bang and a lone equals, a slash ended by LF, '<' then '>=', an
//     empty block comment, most plain punctuation and the bytes 0 and 255
//   - random C-like text in three stretches: sender idling 19% with the
//     receiver stalling 66%, then the other way round, then no idling
//   - in the last stretch: an overlong word that starts as a keyword, an
//     overlong number, 32-bit wrap, then a slash and a '<' each ended by LF
//   - end of input with a word still open, then a few requests after end
// Reset comes once and end of input only at the end, so the stream is one long source.
module tb_c_subset_tokenizer;

   import ctok_pkg::*;

   localparam real        HALF_PERIOD = 5.0;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam int         STRETCH     = 75;    // minimum requests per random stretch
   localparam int         DRAIN_WAIT  = 10;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code    = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [4:0]  rsp_token_kind;
   logic [7:0]  rsp_token_length;
   logic [31:0] rsp_number_value;
   logic [15:0] rsp_line_number;
   logic        rsp_is_last;

   int error_count;
   int tokens_pending;

   // idle rates in percent, changed per stretch
   int send_idle_pct = 0;
   int rcv_stall_pct = 0;

   // source text waiting to be driven
   logic [7:0] source_q [$];

   always #(HALF_PERIOD) clock = ~clock;

   c_subset_tokenizer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_length (rsp_token_length),
      .rsp_number_value (rsp_number_value),
      .rsp_line_number  (rsp_line_number),
      .rsp_is_last      (rsp_is_last)
   );

   token_stream_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_length (rsp_token_length),
      .rsp_number_value (rsp_number_value),
      .rsp_line_number  (rsp_line_number),
      .rsp_is_last      (rsp_is_last),
      .error_count      (error_count),
      .tokens_pending   (tokens_pending)
   );

   // Receiver back-pressure: redrawn every falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   // Valid stays up between back-to-back requests, only the payload moves.
   task automatic send_request(input logic [7:0] ch, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_char_code    = ch;
      req_end_of_input = eoi;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_source();
      while (source_q.size() > 0) send_request(source_q.pop_front(), 1'b0);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) source_q.push_back(s[i]);
   endtask

   function automatic logic [7:0] rand_alpha();
      int r;
      r = $urandom_range(52);
      if (r < 26) return 8'(r) + "a";
      if (r < 52) return 8'(r - 26) + "A";
      return "_";
   endfunction

   function automatic logic [7:0] rand_alnum();
      if ($urandom_range(3) == 0) return 8'($urandom_range(9)) + "0";
      return rand_alpha();
   endfunction

   function automatic string keyword_text(input int k);
      case (k)
         0:       return "int";
         1:       return "void";
         2:       return "if";
         3:       return "else";
         4:       return "while";
         5:       return "for";
         default: return "return";
      endcase
   endfunction

   function automatic string operator_text(input int k);
      case (k)
         0:       return "{";
         1:       return "}";
         2:       return "(";
         3:       return ")";
         4:       return ";";
         5:       return ",";
         6:       return "+";
         7:       return "-";
         8:       return "*";
         9:       return "/";
         10:      return "<";
         11:      return ">";
         12:      return "=";
         13:      return "!";
         14:      return "==";
         15:      return "!=";
         16:      return "<=";
         default: return ">=";
      endcase
   endfunction

   task automatic add_word(input int n);
      source_q.push_back(rand_alpha());
      for (int i = 1; i < n; i++) source_q.push_back(rand_alnum());
   endtask

   task automatic add_number(input int n);
      for (int i = 0; i < n; i++) source_q.push_back(8'($urandom_range(9)) + "0");
   endtask

   // One piece of C-like text. Mostly well formed, with some noise bytes,
   // near-miss keywords and comments that may close early.
   task automatic add_fragment();
      int  sel;
      int  n;
      string kw;
      logic  spaced;
      sel    = $urandom_range(99);
      spaced = 1'b0;
      if (sel < 14) begin
         add_text(keyword_text($urandom_range(6)));
         spaced = 1'b1;
      end else if (sel < 20) begin
         // keyword with one extra character, or cut short
         kw = keyword_text($urandom_range(6));
         if ($urandom_range(1)) begin
            add_text(kw);
            source_q.push_back(rand_alnum());
         end else begin
            add_text(kw.substr(0, kw.len() - 2));
         end
         spaced = 1'b1;
      end else if (sel < 30) begin
         add_word($urandom_range(1, 9));
         spaced = 1'b1;
      end else if (sel < 42) begin
         add_number($urandom_range(1, 12));
         spaced = 1'b1;
      end else if (sel < 62) begin
         add_text(operator_text($urandom_range(17)));
      end else if (sel < 77) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
               0:       add_text(" ");
               1:       add_text("\t");
               2:       add_text("\r");
               default: source_q.push_back(CH_LF);
            endcase
         end
      end else if (sel < 82) begin
         add_text("//");
         n = $urandom_range(8);
         for (int i = 0; i < n; i++) source_q.push_back(8'($urandom_range(255)));
         source_q.push_back(CH_LF);
      end else if (sel < 87) begin
         add_text("/*");
         n = $urandom_range(8);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(4))
               0:       add_text("*");
               1:       add_text("/");
               2:       source_q.push_back(CH_LF);
               3:       add_text(" ");
               default: source_q.push_back(rand_alnum());
            endcase
         end
         add_text("*/");
      end else begin
         source_q.push_back(8'($urandom_range(255)));
      end
      if (spaced && $urandom_range(9) < 7) add_text(" ");
   endtask

   task automatic random_stretch();
      while (source_q.size() < STRETCH) add_fragment();
      send_source();
   endtask

   // Hard stop if the block hangs.
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // stretch one: slow receiver
      send_idle_pct = 19;
      rcv_stall_pct = 66;

      // directed opening text
      add_text("int(9)!a=/");
      source_q.push_back(CH_LF);
      add_text("<>=/**/{;,+-*");
      source_q.push_back(8'h00);
      source_q.push_back(8'hFF);
      send_source();

      random_stretch();

      // stretch two: slow sender
      send_idle_pct = 66;
      rcv_stall_pct = 19;
      random_stretch();

      // stretch three: full rate both ways
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      random_stretch();

      // overlong word that begins like a keyword, overlong number, wrap
      add_text(" return");
      for (int i = 0; i < 254; i++) source_q.push_back(rand_alnum());
      add_text(" ");
      add_number(260);
      add_text("; 4294967295 4294967296 99999999999;");
      send_source();

      // slash and '<' each ended by LF, then a few words
      add_text("x1/");
      source_q.push_back(CH_LF);
      add_text("<");
      source_q.push_back(CH_LF);
      add_text("y tail");
      send_source();

      // end of input with a word open, then requests after the end
      send_request(8'($urandom_range(255)), 1'b1);
      send_request(8'($urandom_range(255)), 1'b0);
      send_request(8'h00, 1'b1);
      send_request("x", 1'b0);
      req_valid = 1'b0;

      while (tokens_pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
